// ----- design/acd_pkg.sv -----
// Shared types, codes and constants for the Avro container deframer.
package acd_pkg;

   localparam int SYNC_BYTES_DEF = 16;

   // Length limit, clipped to 2^32 - 1.
   localparam logic [63:0] LEN_CAP = 64'h0000_0000_FFFF_FFFF;

   localparam logic [31:0] MAX_BLOCK_RST   = 32'd67108864;
   localparam logic [31:0] MAX_ENTRIES_RST = 32'd1048576;

   localparam logic CFG_MAX_BLOCK   = 1'b0;
   localparam logic CFG_MAX_ENTRIES = 1'b1;

   localparam logic [2:0] KIND_KEY      = 3'd0;
   localparam logic [2:0] KIND_VALUE    = 3'd1;
   localparam logic [2:0] KIND_HEADER   = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
   localparam logic [2:0] KIND_BLK_DONE = 3'd4;
   localparam logic [2:0] KIND_STR_DONE = 3'd5;
   localparam logic [2:0] KIND_ERROR    = 3'd6;

   localparam logic [3:0] ERR_MAGIC       = 4'd0;
   localparam logic [3:0] ERR_TRUNC       = 4'd1;
   localparam logic [3:0] ERR_VARINT      = 4'd2;
   localparam logic [3:0] ERR_COUNT       = 4'd3;
   localparam logic [3:0] ERR_META_SIZE   = 4'd4;
   localparam logic [3:0] ERR_ENTRIES     = 4'd5;
   localparam logic [3:0] ERR_KEY_LEN     = 4'd6;
   localparam logic [3:0] ERR_KEY_NUL     = 4'd7;
   localparam logic [3:0] ERR_VALUE_LEN   = 4'd8;
   localparam logic [3:0] ERR_NEG_OBJECTS = 4'd9;
   localparam logic [3:0] ERR_BLOCK_SIZE  = 4'd10;
   localparam logic [3:0] ERR_SYNC        = 4'd11;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic        last_of_field;
      logic [62:0] object_count;
      logic [31:0] payload_size;
      logic [3:0]  error_code;
   } result_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0: m = 8'h4f;
         2'd1: m = 8'h62;
         2'd2: m = 8'h6a;
         default: m = 8'h01;
      endcase
      return m;
   endfunction

endpackage

// ----- design/acd_ram.sv -----
// Generic single-port-write, registered-read RAM.
module acd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/acd_outbuf.sv -----
// Two-entry output buffer (holding register plus skid stage) for results.
module acd_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  acd_pkg::result_type  push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output acd_pkg::result_type  out_data
);
   acd_pkg::result_type main_ff, main_in, skid_ff, skid_in;
   logic                main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   logic                pop;

   assign pop        = main_v_ff & out_ready;
   assign push_ready = ~skid_v_ff;

   always_comb begin
      main_in   = main_ff;
      main_v_in = main_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (!main_v_ff || pop) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            main_v_in = 1'b1;
            skid_v_in = 1'b0;
         end else begin
            main_in   = push_data;
            main_v_in = push;
         end
      end else if (push) begin
         skid_in   = push_data;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_v_ff;
   assign out_data  = main_ff;
endmodule

// ----- design/acd_parse.sv -----
// Container parser: magic, varints, metadata map, sync capture and block framing.
module acd_parse #(
   parameter int SYNC_BYTES = acd_pkg::SYNC_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_input,
   output logic                res_valid,
   output acd_pkg::result_type res
);
   localparam int AW   = SYNC_BYTES > 1 ? $clog2(SYNC_BYTES) : 1;
   localparam int SI_W = $clog2(SYNC_BYTES + 1);

   typedef enum logic [3:0] {
      PH_MAGIC, PH_MAGIC_BAD, PH_M_COUNT, PH_M_BSIZE, PH_K_LEN, PH_K_BYTES,
      PH_K_NUL, PH_V_LEN, PH_V_BYTES, PH_SYNC_CAP, PH_B_COUNT, PH_B_SIZE,
      PH_B_DATA, PH_B_SYNC, PH_B_SYNC_BAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  magic_idx_ff, magic_idx_in;
   logic [63:0] accum_ff, accum_in;
   logic [6:0]  shift_ff, shift_in;
   logic [63:0] items_ff, items_in;
   logic [31:0] entries_ff, entries_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [SI_W-1:0] sync_cnt_ff, sync_cnt_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] max_block_ff, max_entries_ff;

   logic        ram_we;
   logic [7:0]  ram_rdata;

   logic [63:0] acc_new, v, lim, start_c, items_dec;
   logic        v_done, v_ovf, last, do_fail, bad_len;
   logic [3:0]  fail_code;
   logic [31:0] bytes_dec;
   logic [SI_W-1:0] sync_inc;

   acd_ram #(.WIDTH(8), .DEPTH(SYNC_BYTES)) u_sync_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (sync_cnt_ff[AW-1:0]),
      .wdata (data_byte),
      .raddr (sync_cnt_in[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      acc_new   = accum_ff | ({57'd0, data_byte[6:0]} << shift_ff);
      v_ovf     = (shift_ff >= 7'd63) && ((data_byte & 8'hfe) != 8'd0);
      v_done    = ~data_byte[7];
      v         = (acc_new >> 1) ^ {64{acc_new[0]}};
      lim       = ({32'd0, max_block_ff} < acd_pkg::LEN_CAP) ? {32'd0, max_block_ff}
                                                            : acd_pkg::LEN_CAP;
      bad_len   = v[63] || (v > lim);
      start_c   = (phase_ff == PH_M_COUNT) ? v : items_ff;
      items_dec = items_ff - 64'd1;
      bytes_dec = bytes_ff - 32'd1;
      last      = (bytes_dec == 32'd0);
      sync_inc  = sync_cnt_ff + 1'b1;
   end

   always_comb begin
      phase_in     = phase_ff;
      magic_idx_in = magic_idx_ff;
      accum_in     = accum_ff;
      shift_in     = shift_ff;
      items_in     = items_ff;
      entries_in   = entries_ff;
      bytes_in     = bytes_ff;
      sync_cnt_in  = sync_cnt_ff;
      stopped_in   = stopped_ff;
      ram_we       = 1'b0;
      res_valid    = 1'b0;
      res          = '0;
      do_fail      = 1'b0;
      fail_code    = acd_pkg::ERR_TRUNC;

      if (accept && !stopped_ff) begin
         if (end_of_input) begin
            if (phase_ff == PH_B_COUNT && shift_ff == 7'd0) begin
               stopped_in = 1'b1;
               res_valid  = 1'b1;
               res.kind   = acd_pkg::KIND_STR_DONE;
            end else begin
               do_fail = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_MAGIC, PH_MAGIC_BAD: begin
                  if (data_byte != acd_pkg::magic_byte(magic_idx_ff)) begin
                     phase_in = PH_MAGIC_BAD;
                  end
                  if (magic_idx_ff == 2'd3) begin
                     if (phase_in == PH_MAGIC_BAD) begin
                        do_fail   = 1'b1;
                        fail_code = acd_pkg::ERR_MAGIC;
                     end else begin
                        phase_in = PH_M_COUNT;
                        accum_in = '0;
                        shift_in = '0;
                     end
                  end else begin
                     magic_idx_in = magic_idx_ff + 2'd1;
                  end
               end
               PH_M_COUNT, PH_M_BSIZE, PH_K_LEN, PH_V_LEN, PH_B_COUNT,
               PH_B_SIZE: begin
                  if (v_ovf) begin
                     accum_in  = '0;
                     shift_in  = '0;
                     do_fail   = 1'b1;
                     fail_code = acd_pkg::ERR_VARINT;
                  end else if (!v_done) begin
                     accum_in = acc_new;
                     shift_in = shift_ff + 7'd7;
                  end else begin
                     accum_in = '0;
                     shift_in = '0;
                     case (phase_ff)
                        PH_M_COUNT, PH_M_BSIZE: begin
                           if (phase_ff == PH_M_COUNT && v == 64'd0) begin
                              phase_in    = PH_SYNC_CAP;
                              sync_cnt_in = '0;
                           end else if (phase_ff == PH_M_COUNT && v[63]) begin
                              if (v[62:0] == 63'd0) begin
                                 do_fail   = 1'b1;
                                 fail_code = acd_pkg::ERR_COUNT;
                              end else begin
                                 items_in = 64'd0 - v;
                                 phase_in = PH_M_BSIZE;
                              end
                           end else if (phase_ff == PH_M_BSIZE && v[63]) begin
                              do_fail   = 1'b1;
                              fail_code = acd_pkg::ERR_META_SIZE;
                           end else if ((start_c > {32'd0, max_entries_ff}) ||
                                        (entries_ff >
                                         (max_entries_ff - start_c[31:0]))) begin
                              do_fail   = 1'b1;
                              fail_code = acd_pkg::ERR_ENTRIES;
                           end else begin
                              entries_in = entries_ff + start_c[31:0];
                              items_in   = start_c;
                              phase_in   = PH_K_LEN;
                           end
                        end
                        PH_K_LEN: begin
                           if (bad_len) begin
                              do_fail   = 1'b1;
                              fail_code = acd_pkg::ERR_KEY_LEN;
                           end else begin
                              bytes_in = v[31:0];
                              phase_in = (v != 64'd0) ? PH_K_BYTES : PH_V_LEN;
                           end
                        end
                        PH_V_LEN: begin
                           if (bad_len) begin
                              do_fail   = 1'b1;
                              fail_code = acd_pkg::ERR_VALUE_LEN;
                           end else begin
                              bytes_in = v[31:0];
                              if (v != 64'd0) begin
                                 phase_in = PH_V_BYTES;
                              end else begin
                                 items_in = items_dec;
                                 phase_in = (items_dec != 64'd0) ? PH_K_LEN : PH_M_COUNT;
                              end
                           end
                        end
                        PH_B_COUNT: begin
                           if (v[63]) begin
                              do_fail   = 1'b1;
                              fail_code = acd_pkg::ERR_NEG_OBJECTS;
                           end else begin
                              items_in = v;
                              phase_in = PH_B_SIZE;
                           end
                        end
                        default: begin
                           if (bad_len) begin
                              do_fail   = 1'b1;
                              fail_code = acd_pkg::ERR_BLOCK_SIZE;
                           end else begin
                              bytes_in          = v[31:0];
                              sync_cnt_in       = '0;
                              phase_in          = (v != 64'd0) ? PH_B_DATA : PH_B_SYNC;
                              res_valid         = 1'b1;
                              res.kind          = acd_pkg::KIND_HEADER;
                              res.object_count  = items_ff[62:0];
                              res.payload_size  = v[31:0];
                           end
                        end
                     endcase
                  end
               end
               PH_K_BYTES, PH_K_NUL: begin
                  bytes_in = bytes_dec;
                  if (data_byte == 8'd0 || phase_ff == PH_K_NUL) begin
                     // drop key bytes from the NUL onward
                     phase_in = PH_K_NUL;
                     if (last) begin
                        do_fail   = 1'b1;
                        fail_code = acd_pkg::ERR_KEY_NUL;
                     end
                  end else begin
                     if (last) begin
                        phase_in = PH_V_LEN;
                     end
                     res_valid         = 1'b1;
                     res.kind          = acd_pkg::KIND_KEY;
                     res.out_byte      = data_byte;
                     res.last_of_field = last;
                  end
               end
               PH_V_BYTES: begin
                  bytes_in = bytes_dec;
                  if (last) begin
                     items_in = items_dec;
                     phase_in = (items_dec != 64'd0) ? PH_K_LEN : PH_M_COUNT;
                  end
                  res_valid         = 1'b1;
                  res.kind          = acd_pkg::KIND_VALUE;
                  res.out_byte      = data_byte;
                  res.last_of_field = last;
               end
               PH_SYNC_CAP: begin
                  ram_we      = 1'b1;
                  sync_cnt_in = sync_inc;
                  if (sync_inc >= SI_W'(SYNC_BYTES)) begin
                     sync_cnt_in = '0;
                     phase_in    = PH_B_COUNT;
                  end
               end
               PH_B_DATA: begin
                  bytes_in = bytes_dec;
                  if (last) begin
                     phase_in    = PH_B_SYNC;
                     sync_cnt_in = '0;
                  end
                  res_valid         = 1'b1;
                  res.kind          = acd_pkg::KIND_PAYLOAD;
                  res.out_byte      = data_byte;
                  res.last_of_field = last;
               end
               PH_B_SYNC, PH_B_SYNC_BAD: begin
                  // ram_rdata holds the marker byte at sync_cnt_ff (prefetched)
                  if (data_byte != ram_rdata) begin
                     phase_in = PH_B_SYNC_BAD;
                  end
                  sync_cnt_in = sync_inc;
                  if (sync_inc >= SI_W'(SYNC_BYTES)) begin
                     sync_cnt_in = '0;
                     if (phase_in == PH_B_SYNC_BAD) begin
                        do_fail   = 1'b1;
                        fail_code = acd_pkg::ERR_SYNC;
                     end else begin
                        phase_in  = PH_B_COUNT;
                        res_valid = 1'b1;
                        res.kind  = acd_pkg::KIND_BLK_DONE;
                     end
                  end
               end
               default: begin
                  stopped_in = 1'b1;
               end
            endcase
         end
      end

      if (do_fail) begin
         stopped_in     = 1'b1;
         res_valid      = 1'b1;
         res            = '0;
         res.kind       = acd_pkg::KIND_ERROR;
         res.error_code = fail_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAGIC;
         magic_idx_ff   <= '0;
         accum_ff       <= '0;
         shift_ff       <= '0;
         items_ff       <= '0;
         entries_ff     <= '0;
         bytes_ff       <= '0;
         sync_cnt_ff    <= '0;
         stopped_ff     <= 1'b0;
         max_block_ff   <= acd_pkg::MAX_BLOCK_RST;
         max_entries_ff <= acd_pkg::MAX_ENTRIES_RST;
      end else begin
         phase_ff     <= phase_in;
         magic_idx_ff <= magic_idx_in;
         accum_ff     <= accum_in;
         shift_ff     <= shift_in;
         items_ff     <= items_in;
         entries_ff   <= entries_in;
         bytes_ff     <= bytes_in;
         sync_cnt_ff  <= sync_cnt_in;
         stopped_ff   <= stopped_in;
         if (csr_we && csr_index == acd_pkg::CFG_MAX_BLOCK) begin
            max_block_ff <= csr_wdata;
         end
         if (csr_we && csr_index == acd_pkg::CFG_MAX_ENTRIES) begin
            max_entries_ff <= csr_wdata;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stop flag cleared without reset");

   a_silent_after_stop: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !res_valid)
      else $error("result produced after stop");

   a_sync_cnt_range: assert property (@(posedge clock) disable iff (reset)
      sync_cnt_ff < SI_W'(SYNC_BYTES))
      else $error("sync index out of range");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      shift_ff <= 7'd63)
      else $error("varint shift out of range");
`endif
endmodule

// ----- design/avro_container_deframer.sv -----
// Top level of the Avro object container file deframer.
// Usage:
//   req_*: one container file byte per transaction (tdata) with an
//     end-of-input flag (tuser); the flag closes the stream.
//   rsp_*: zero or one result per input transaction: key, value and payload
//     bytes, block headers (object count and payload size), block done,
//     stream done or a single error code. tuser carries the kind, tlast marks
//     the final byte of a key, value or payload.
//   csr_*: write max_block_bytes (index 0) and max_meta_entries (index 1)
//     while the block is idle.
// Throughput is one byte per cycle while req_tready is high; the sync marker lives
// in a RAM whose registered read is addressed with the next sync index, so the compare never stalls.
// Each result passes through the output buffer registers before it appears on rsp_*.
// A two-entry output buffer lets one more input transaction in while a result
// waits; req_tready drops only when both entries are full.
// Reset (synchronous) returns the parser to the magic check and restores the
// register defaults; the sync RAM needs no clearing.
// After an error or stream done every further input is consumed silently.
module avro_container_deframer #(
   parameter int SYNC_BYTES = acd_pkg::SYNC_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic [0:0]    req_tuser,   // [0] end_of_input
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // [7:0] out_byte, [70:8] object_count,
                                      // [102:71] payload_size, [106:103] error_code
   output logic [2:0]    rsp_tuser,   // [2:0] kind
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata
);
   logic                accept;
   logic                res_valid;
   acd_pkg::result_type res, out_res;

   assign accept = req_tvalid & req_tready;

   acd_parse #(.SYNC_BYTES(SYNC_BYTES)) u_parse (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .data_byte    (req_tdata),
      .end_of_input (req_tuser[0]),
      .res_valid    (res_valid),
      .res          (res)
   );

   acd_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_res)
   );

   assign rsp_tdata = {5'd0, out_res.error_code, out_res.payload_size,
                       out_res.object_count, out_res.out_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last_of_field;
endmodule
